### hdl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and constants for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

  // Default sequence capacity
  localparam int unsigned MaxItems = 64;

  // Fixed payload widths
  localparam int unsigned HeightW = 32;
  localparam int unsigned LenOutW = 7;

  // Input transfer
  typedef struct packed {
    logic signed [HeightW-1:0] height;
    logic                      last_item;
  } lis_in_t;

  // Result transfer
  typedef struct packed {
    logic        [LenOutW-1:0] chain_length;
    logic signed [HeightW-1:0] chain_value;
    logic                      last_in_run;
    logic                      overflowed;
  } lis_out_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;   // new item: chain length back to one
    logic sample;  // read data from the entry memory is valid
  } lis_scan_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_TRACE_ISSUE,
    S_TRACE,
    S_EMIT
  } lis_state_e;

endpackage

### hdl/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/lis_scan.sv
// ----------------------------------------------------------------------------
// lis_scan
// Compare unit: folds one stored entry per cycle into the best chain so far
// for the item under work.
// ----------------------------------------------------------------------------
module lis_scan #(
  parameter int unsigned MAX_ITEMS = lis_pkg::MaxItems
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lis_pkg::lis_scan_ctrl_t              ctrl_i,
  input  logic signed [lis_pkg::HeightW-1:0]   height_i,
  input  logic signed [lis_pkg::HeightW-1:0]   ent_value_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]       ent_len_i,
  input  logic [$clog2(MAX_ITEMS)-1:0]         ent_idx_i,
  output logic [$clog2(MAX_ITEMS+1)-1:0]       cur_len_o,
  output logic [$clog2(MAX_ITEMS)-1:0]         pred_o
);
  import lis_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] cur_q, cur_d;
  logic [AW-1:0] pred_q, pred_d;
  logic [CW:0]   len_inc;
  logic          better;

  // strictly smaller predecessor with a strictly longer chain; earliest wins
  assign len_inc = {1'b0, ent_len_i} + (CW+1)'(1);
  assign better  = (height_i > ent_value_i) && (len_inc > {1'b0, cur_q});

  always_comb begin
    cur_d  = cur_q;
    pred_d = pred_q;
    if (ctrl_i.clear) begin
      cur_d  = CW'(1);
      pred_d = '0;
    end else if (ctrl_i.sample && better) begin
      cur_d  = len_inc[CW-1:0];
      pred_d = ent_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= CW'(1);
      pred_q <= '0;
    end else begin
      cur_q  <= cur_d;
      pred_q <= pred_d;
    end
  end

  assign cur_len_o = cur_q;
  assign pred_o    = pred_q;

endmodule

### hdl/longest_increasing_subsequence.sv
// Scan: an item below capacity keeps busy_o high while it reads its n stored entries,
//   one stored entry read per cycle from the entry memory's single read port.
// A last item adds a traceback (L = best length, one dependent read per cycle), then L
//   results, one per cycle, the first in the cycle after the first reverse-buffer read.
// Throughput: next item taken in the cycle after busy_o falls; receiver cannot stall.
// Reset: asynchronous, active low; clears the sequence state, memories keep contents.
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Quadratic dynamic-programming longest strictly increasing subsequence,
// built around an entry memory (value, chain length, predecessor) and a
// reverse buffer that turns the traceback into arrival order.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
  parameter int unsigned MAX_ITEMS = lis_pkg::MaxItems
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  lis_pkg::lis_in_t  in_i,
  output logic              strobe_o,
  output lis_pkg::lis_out_t res_o
);
  import lis_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EW = HeightW + CW + AW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

  lis_state_e state_q, state_d;

  // sequence state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] best_len_q, best_len_d;
  logic [AW-1:0] best_end_q, best_end_d;
  logic          drop_q, drop_d;

  // item under work
  logic signed [HeightW-1:0] h_q, h_d;
  logic                      last_q, last_d;

  // scan, trace and emit counters
  logic [AW-1:0] j_q, j_d;
  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] e_q, e_d;
  logic          iss_q, iss_d;
  logic          opend_q, opend_d;
  logic          olast_q, olast_d;

  logic          accept;
  logic          scan_issue;
  logic          trace_end;
  logic [AW-1:0] len_m1;

  // memory ports
  logic          ent_we;
  logic [AW-1:0] ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic          rev_we;
  logic [HeightW-1:0] rev_rdata;

  logic signed [HeightW-1:0] ent_value;
  logic [CW-1:0]             ent_len;
  logic [AW-1:0]             ent_pred;

  lis_scan_ctrl_t scan_ctrl;
  logic [CW-1:0]  cur_len;
  logic [AW-1:0]  cur_pred;

  assign busy_o     = (state_q != S_IDLE);
  assign accept     = start_i && !busy_o;
  assign scan_issue = ({1'b0, j_q} < (AW+1)'(cnt_q));
  assign len_m1     = AW'(best_len_q - CW'(1));
  assign trace_end  = (k_q == len_m1);

  assign ent_value = $signed(ent_rdata[EW-1 -: HeightW]);
  assign ent_len   = ent_rdata[AW +: CW];
  assign ent_pred  = ent_rdata[AW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < MaxCnt) begin
            state_d = S_SCAN;
          end else if (in_i.last_item) begin
            state_d = S_TRACE_ISSUE;
          end
        end
      end
      S_SCAN: begin
        if (!scan_issue) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        state_d = last_q ? S_TRACE_ISSUE : S_IDLE;
      end
      S_TRACE_ISSUE: begin
        state_d = S_TRACE;
      end
      S_TRACE: begin
        if (trace_end) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!iss_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory and compare-unit controls
  always_comb begin
    ent_we    = 1'b0;
    rev_we    = 1'b0;
    ent_raddr = j_q;
    scan_ctrl = '{clear: accept, sample: rd_pend_q};
    case (state_q)
      S_WRITE:       ent_we    = 1'b1;
      S_TRACE_ISSUE: ent_raddr = best_end_q;
      S_TRACE: begin
        rev_we    = 1'b1;
        ent_raddr = ent_pred;  // follow the chain one step per cycle
      end
      default: ;
    endcase
  end

  assign ent_wdata = {h_q, cur_len, cur_pred};

  // datapath updates
  always_comb begin
    cnt_d      = cnt_q;
    best_len_d = best_len_q;
    best_end_d = best_end_q;
    drop_d     = drop_q;
    h_d        = h_q;
    last_d     = last_q;
    j_d        = j_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    k_d        = k_q;
    e_d        = e_q;
    iss_d      = iss_q;
    opend_d    = 1'b0;
    olast_d    = olast_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          h_d    = in_i.height;
          last_d = in_i.last_item;
          j_d    = '0;
          if (cnt_q == MaxCnt) begin
            drop_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // one read per stored entry, compared in the cycle after it is issued
        rd_pend_d = scan_issue;
        rd_idx_d  = j_q;
        if (scan_issue) begin
          j_d = j_q + AW'(1);
        end
      end
      S_WRITE: begin
        if (cur_len > best_len_q) begin
          best_len_d = cur_len;
          best_end_d = cnt_q[AW-1:0];
        end
        cnt_d = cnt_q + CW'(1);
      end
      S_TRACE_ISSUE: begin
        k_d = '0;
      end
      S_TRACE: begin
        if (trace_end) begin
          e_d   = len_m1;
          iss_d = 1'b1;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (iss_q) begin
          // read the reverse buffer from its far end
          opend_d = 1'b1;
          olast_d = (e_q == '0);
          if (e_q == '0) begin
            iss_d = 1'b0;
          end else begin
            e_d = e_q - AW'(1);
          end
        end else begin
          // final result goes out this cycle; start a new sequence
          cnt_d      = '0;
          best_len_d = CW'(1);
          best_end_d = '0;
          drop_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      best_len_q <= CW'(1);
      best_end_q <= '0;
      drop_q     <= 1'b0;
      j_q        <= '0;
      rd_pend_q  <= 1'b0;
      k_q        <= '0;
      e_q        <= '0;
      iss_q      <= 1'b0;
      opend_q    <= 1'b0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      best_len_q <= best_len_d;
      best_end_q <= best_end_d;
      drop_q     <= drop_d;
      j_q        <= j_d;
      rd_pend_q  <= rd_pend_d;
      k_q        <= k_d;
      e_q        <= e_d;
      iss_q      <= iss_d;
      opend_q    <= opend_d;
      olast_q    <= olast_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    last_q   <= last_d;
    rd_idx_q <= rd_idx_d;
  end

  // entry memory: value, chain length, predecessor
  lis_ram #(
    .Width (EW),
    .Depth (MAX_ITEMS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // reverse buffer: traced values, end of chain first
  lis_ram #(
    .Width (HeightW),
    .Depth (MAX_ITEMS)
  ) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .waddr_i (k_q),
    .wdata_i (ent_rdata[EW-1 -: HeightW]),
    .raddr_i (e_q),
    .rdata_o (rev_rdata)
  );

  lis_scan #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .height_i    (h_q),
    .ent_value_i (ent_value),
    .ent_len_i   (ent_len),
    .ent_idx_i   (rd_idx_q),
    .cur_len_o   (cur_len),
    .pred_o      (cur_pred)
  );

  // result transfer
  assign strobe_o           = opend_q;
  assign res_o.chain_length = LenOutW'(best_len_q);
  assign res_o.chain_value  = $signed(rev_rdata);
  assign res_o.last_in_run  = olast_q;
  assign res_o.overflowed   = drop_q;

endmodule

### hdl/lis_chk.sv
// ----------------------------------------------------------------------------
// lis_chk
// Port-level checks on the result run of the subsequence block.
// ----------------------------------------------------------------------------
module lis_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              strobe_o,
  input lis_pkg::lis_out_t res_o
);
  import lis_pkg::*;

  // results only appear while a sequence is being worked off
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("result transfer while idle");

  // a run has no gaps until its final result
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !res_o.last_in_run |=> strobe_o)
    else $error("gap inside a result run");

  // the block is free right after the final result
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.last_in_run |=> !busy_o)
    else $error("still busy after the final result");

  // length and overflow flag are the same across a run
  a_run_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && $past(strobe_o) && !$past(res_o.last_in_run)
      |-> $stable(res_o.chain_length) && $stable(res_o.overflowed))
    else $error("run header changed mid-run");

endmodule

bind longest_increasing_subsequence lis_chk u_lis_chk (.*);

### verif/longest_increasing_subsequence_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_test
// Self-checking bench for the longest increasing subsequence block. Sequences
// go in through the start/busy handshake with random gaps. A local dynamic-
// programming predictor builds the expected chain for each sequence, and
// every strobed result is compared field by field, in order, against it.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_test;
  import lis_pkg::*;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandItems  = 70;
  localparam int          HeightMin  = 32'sh8000_0000;
  localparam int          HeightMax  = 32'sh7fff_ffff;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  lis_in_t  in_i;
  logic     strobe_o;
  lis_out_t res_o;

  // Predictor state, one sequence at a time
  logic signed [HeightW-1:0] seq_value [MaxItems];
  int       seq_len  [MaxItems];
  int       seq_pred [MaxItems];
  int       seq_count;
  int       best_len;
  int       best_end;
  bit       seq_dropped;
  lis_out_t expected_chain_q [$];

  // Run statistics
  int errors;
  int items_sent;
  int runs_sent;
  int overflow_runs;
  int results_checked;
  int idle_cycles;
  bit no_idle;

  longest_increasing_subsequence #(
    .MAX_ITEMS(MaxItems)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Sequence state back to its cleared values
  function automatic void clear_chain();
    seq_count   = 0;
    best_len    = 1;
    best_end    = 0;
    seq_dropped = 1'b0;
  endfunction

  // Update the predictor with one accepted item; on the last item queue the run
  task automatic predict_chain(lis_in_t item);
    int cur;
    int pred;
    int n;
    int pos;
    logic signed [HeightW-1:0] trace [MaxItems];
    lis_out_t r;
    if (seq_count < MaxItems) begin
      cur  = 1;
      pred = 0;
      for (int j = 0; j < seq_count; j++) begin
        // earliest smaller predecessor with a longer chain wins
        if ($signed(item.height) > seq_value[j] && seq_len[j] + 1 > cur) begin
          cur  = seq_len[j] + 1;
          pred = j;
        end
      end
      seq_value[seq_count] = item.height;
      seq_len[seq_count]   = cur;
      seq_pred[seq_count]  = pred;
      if (cur > best_len) begin
        best_len = cur;
        best_end = seq_count;
      end
      seq_count++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (item.last_item) begin
      n   = (best_len > MaxItems) ? MaxItems : best_len;
      pos = best_end;
      // walk back from the best end, then queue in arrival order
      for (int k = 0; k < n; k++) begin
        trace[k] = seq_value[pos % MaxItems];
        pos      = seq_pred[pos % MaxItems];
      end
      for (int k = 0; k < n; k++) begin
        r.chain_length = LenOutW'(best_len);
        r.chain_value  = trace[n-1-k];
        r.last_in_run  = (k == n - 1);
        r.overflowed   = seq_dropped;
        expected_chain_q.push_back(r);
      end
      runs_sent++;
      if (seq_dropped) overflow_runs++;
      clear_chain();
    end
  endtask

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item after an optional gap and wait for its transfer
  task automatic send_item(logic signed [HeightW-1:0] height, bit last, int gap);
    lis_in_t item;
    item.height    = height;
    item.last_item = last;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    in_i    = item;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    predict_chain(item);
  endtask

  // Lower start and hold off until every queued result has come back
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_chain_q.size() != 0) @(posedge clk_i);
  endtask

  // Single-item sequences at the extremes of the value range and at -1
  task automatic test_single_item();
    send_item(HeightMin, 1'b1, pick_gap());
    send_item(HeightMax, 1'b1, pick_gap());
    send_item(-1, 1'b1, pick_gap());
    drain();
  endtask

  // Rising, falling and flat sequences
  task automatic test_monotone();
    send_item(HeightMin, 1'b0, 0);
    send_item(-1, 1'b0, 0);
    send_item(0, 1'b0, 0);
    send_item(1, 1'b0, 0);
    send_item(HeightMax, 1'b1, 0);
    send_item(HeightMax, 1'b0, pick_gap());
    send_item(0, 1'b0, pick_gap());
    send_item(HeightMin, 1'b1, pick_gap());
    // equal values never extend a strictly increasing chain
    send_item(5, 1'b0, pick_gap());
    send_item(5, 1'b0, pick_gap());
    send_item(5, 1'b1, pick_gap());
    drain();
  endtask

  // Earliest predecessor wins; best end moves only on a strictly longer chain
  task automatic test_ties();
    send_item(1, 1'b0, 0);
    send_item(3, 1'b0, 0);
    send_item(2, 1'b0, 0);
    send_item(4, 1'b1, 0);
    send_item(10, 1'b0, pick_gap());
    send_item(20, 1'b0, pick_gap());
    send_item(5, 1'b0, pick_gap());
    send_item(15, 1'b1, pick_gap());
    drain();
  endtask

  // Full store with the longest possible chain, then items past capacity
  task automatic test_capacity();
    for (int k = 0; k < MaxItems; k++) begin
      send_item(HeightMin + k * 40000000, k == MaxItems - 1, pick_gap());
    end
    drain();
    for (int k = 0; k < MaxItems + 3; k++) begin
      send_item($urandom(), k == MaxItems + 2, pick_gap());
    end
    drain();
  endtask

  // Value source for random sequences, one flavor per sequence
  function automatic logic signed [HeightW-1:0] next_height(int flavor,
                                                           inout int walk);
    int r;
    case (flavor)
      0: return $urandom();
      1: return $signed($urandom_range(0, 15)) - 8;
      2: begin
        walk = walk + $signed($urandom_range(0, 20)) - 5;
        return walk;
      end
      default: begin
        r = $urandom_range(0, 4);
        case (r)
          0: return HeightMin;
          1: return HeightMax;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // Random sequences: mostly short, some long, a few past capacity
  task automatic test_random();
    int start_items;
    int len;
    int r;
    int flavor;
    int walk;
    start_items = items_sent;
    while (items_sent - start_items < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 10);
      else if (r < 92) len = $urandom_range(11, 30);
      else len = $urandom_range(31, MaxItems + 6);
      flavor  = $urandom_range(0, 3);
      walk    = $urandom();
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        send_item(next_height(flavor, walk), k == len - 1, pick_gap());
      end
      no_idle = 1'b0;
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    lis_out_t exp_r;
    if (rst_ni && strobe_o) begin
      if (expected_chain_q.size() == 0) begin
        $display("%0t: unexpected result chain_value %0d", $time, res_o.chain_value);
        errors++;
      end else begin
        exp_r = expected_chain_q.pop_front();
        results_checked++;
        if (res_o.chain_length !== exp_r.chain_length) begin
          $display("%0t: chain_length expected %0d actual %0d", $time,
                   exp_r.chain_length, res_o.chain_length);
          errors++;
        end
        if (res_o.chain_value !== exp_r.chain_value) begin
          $display("%0t: chain_value expected %0d actual %0d", $time,
                   exp_r.chain_value, res_o.chain_value);
          errors++;
        end
        if (res_o.last_in_run !== exp_r.last_in_run) begin
          $display("%0t: last_in_run expected %0b actual %0b", $time,
                   exp_r.last_in_run, res_o.last_in_run);
          errors++;
        end
        if (res_o.overflowed !== exp_r.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time,
                   exp_r.overflowed, res_o.overflowed);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || strobe_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("Verification failed");
    $finish;
  end

  // Test sequence
  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    in_i            = '0;
    errors          = 0;
    items_sent      = 0;
    runs_sent       = 0;
    overflow_runs   = 0;
    results_checked = 0;
    no_idle         = 1'b0;
    clear_chain();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_item();
    test_monotone();
    test_ties();
    test_capacity();
    test_random();

    // trailing window for stray results
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items in %0d sequences, %0d of them past capacity;",
             items_sent, runs_sent, overflow_runs);
    $display("compared %0d chain values, %0d mismatches.", results_checked, errors);
    if (errors == 0 && expected_chain_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lis_pkg.sv
hdl/lis_ram.sv
hdl/lis_scan.sv
hdl/longest_increasing_subsequence.sv
hdl/lis_chk.sv
verif/longest_increasing_subsequence_test.sv
